/* design/ema_pkg.sv */
// Shared constants for the exponential moving average core.
package ema_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int WINDOW_BITS_DEF   = 24;

  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;
  localparam int REG_BITS   = 2;

  localparam logic [REG_BITS-1:0] REG_SAMPLE_FORMAT  = 2'd0;
  localparam logic [REG_BITS-1:0] REG_STEREO_MODE    = 2'd1;
  localparam logic [REG_BITS-1:0] REG_WINDOW_SAMPLES = 2'd2;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  localparam logic [1:0] FORMAT_RESET = FMT_S16;

endpackage

/* design/exponential_moving_average_core.sv */
// Exponential moving average core: one average per channel, serial divider.
// Each accepted sample passes through the states S_DIFF, S_DIV, S_ACC, S_ROUND and S_EMIT
// in that order; the divider retires one quotient bit per cycle in S_DIV.
// A new sample word is stalled until the last one's result is emitted; a stalled result
// holds S_EMIT, and so the input, for as long as it waits.
// Reset: both averages and the channel toggle clear, registers return to defaults.
module exponential_moving_average_core #(
  parameter int FRACTION_BITS = ema_pkg::FRACTION_BITS_DEF,
  parameter int WINDOW_BITS   = ema_pkg::WINDOW_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ema_pkg::PADDR_BITS-1:0] paddr,
  input  logic [ema_pkg::PDATA_BITS-1:0] pwdata,
  output logic [ema_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [31:0]             sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [31:0]             smoothed,
  output logic                           channel
);
  import ema_pkg::*;

  localparam int AVG_BITS  = 33 + FRACTION_BITS;
  localparam int DIFF_BITS = AVG_BITS + 1;
  localparam int CNT_BITS  = $clog2(AVG_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(AVG_BITS - 1);
  localparam logic signed [AVG_BITS-1:0] ROUND_BIAS =
    AVG_BITS'((64'd1 << FRACTION_BITS) - 64'd1);

  typedef enum logic [2:0] {S_IDLE, S_DIFF, S_DIV, S_ACC, S_ROUND, S_EMIT} state_t;

  state_t                      state;
  logic [1:0]                  sample_format;
  logic                        stereo_mode;
  logic [WINDOW_BITS-1:0]      window_samples;
  logic signed [AVG_BITS-1:0]  average_left;
  logic signed [AVG_BITS-1:0]  average_right;
  logic                        next_is_right;
  logic signed [31:0]          x_reg;
  logic                        chan_reg;
  logic                        neg;
  logic [AVG_BITS-1:0]         dvd;
  logic [WINDOW_BITS-1:0]      rem;
  logic [CNT_BITS-1:0]         cnt;
  logic signed [AVG_BITS-1:0]  acc_reg;
  logic signed [31:0]          res_reg;

  logic                        cfg_write;
  logic                        in_accept;
  logic                        in_chan;
  logic signed [31:0]          x_in;
  logic [WINDOW_BITS-1:0]      divisor;
  logic [WINDOW_BITS:0]        trial;
  logic [WINDOW_BITS:0]        trial_sub;
  logic                        trial_ge;
  logic signed [AVG_BITS-1:0]  avg_sel;
  logic signed [DIFF_BITS-1:0] avg_ext;
  logic signed [DIFF_BITS-1:0] x_scaled;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [DIFF_BITS-1:0] diff_mag;
  logic signed [DIFF_BITS-1:0] quot;
  logic signed [DIFF_BITS-1:0] sum;
  logic signed [AVG_BITS-1:0]  biased;
  logic signed [AVG_BITS-1:0]  shifted;
  logic signed [32:0]          ipart;
  logic signed [32:0]          lo;
  logic signed [32:0]          hi;
  logic signed [31:0]          clamped;

  assign pready       = 1'b1;
  assign cfg_write    = psel && penable && pwrite;
  assign sample_stall = (state != S_IDLE);
  assign in_accept    = sample_valid && !sample_stall;
  assign in_chan      = stereo_mode && next_is_right;

  always_comb begin
    case (paddr[REG_BITS+1:2])
      REG_SAMPLE_FORMAT:  prdata = PDATA_BITS'(sample_format);
      REG_STEREO_MODE:    prdata = PDATA_BITS'(stereo_mode);
      REG_WINDOW_SAMPLES: prdata = PDATA_BITS'(window_samples);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    case (sample_format)
      FMT_U8:  x_in = {24'd0, sample[7:0]};
      FMT_S16: x_in = {{16{sample[15]}}, sample[15:0]};
      default: x_in = sample;
    endcase
  end

  assign divisor   = (window_samples == '0) ? WINDOW_BITS'(1) : window_samples;
  assign trial     = {rem, dvd[AVG_BITS-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign trial_ge  = (trial >= {1'b0, divisor});

  assign avg_sel  = chan_reg ? average_right : average_left;
  assign avg_ext  = DIFF_BITS'(avg_sel);
  assign x_scaled = DIFF_BITS'(x_reg) <<< FRACTION_BITS;
  assign diff     = x_scaled - avg_ext;
  assign diff_mag = diff[DIFF_BITS-1] ? -diff : diff;
  assign quot     = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  assign sum      = avg_ext + quot;

  assign biased  = acc_reg + (acc_reg[AVG_BITS-1] ? ROUND_BIAS : '0);
  assign shifted = biased >>> FRACTION_BITS;
  assign ipart   = shifted[32:0];

  always_comb begin
    case (sample_format)
      FMT_U8: begin
        lo = 33'sd0;
        hi = 33'sd255;
      end
      FMT_S16: begin
        lo = -33'sd32768;
        hi = 33'sd32767;
      end
      default: begin
        lo = -33'sd2147483648;
        hi = 33'sd2147483647;
      end
    endcase
    if (ipart < lo) begin
      clamped = lo[31:0];
    end else if (ipart > hi) begin
      clamped = hi[31:0];
    end else begin
      clamped = ipart[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sample_format  <= FORMAT_RESET;
      stereo_mode    <= 1'b0;
      window_samples <= WINDOW_BITS'(1);
      average_left   <= '0;
      average_right  <= '0;
      next_is_right  <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[REG_BITS+1:2])
          REG_SAMPLE_FORMAT:  sample_format  <= pwdata[1:0];
          REG_STEREO_MODE:    stereo_mode    <= pwdata[0];
          REG_WINDOW_SAMPLES: window_samples <= pwdata[WINDOW_BITS-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            x_reg         <= x_in;
            chan_reg      <= in_chan;
            next_is_right <= stereo_mode && !in_chan;
            state         <= S_DIFF;
          end
        end
        S_DIFF: begin
          neg   <= diff[DIFF_BITS-1];
          dvd   <= diff_mag[AVG_BITS-1:0];
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= trial_ge ? trial_sub[WINDOW_BITS-1:0] : trial[WINDOW_BITS-1:0];
          dvd <= {dvd[AVG_BITS-2:0], trial_ge};
          cnt <= cnt + CNT_BITS'(1);
          if (cnt == CNT_LAST) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc_reg <= sum[AVG_BITS-1:0];
          if (chan_reg) begin
            average_right <= sum[AVG_BITS-1:0];
          end else begin
            average_left <= sum[AVG_BITS-1:0];
          end
          state <= S_ROUND;
        end
        S_ROUND: begin
          res_reg <= clamped;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            smoothed     <= res_reg;
            channel      <= chan_reg;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_DIFF)
    else $error("accepted sample did not start the datapath");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == CNT_LAST) |=> state == S_ACC)
    else $error("divider did not finish after its last step");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_EMIT)
    else $error("result word raised outside the emit step");

  a_avg_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_ACC |=> $stable(average_left) && $stable(average_right))
    else $error("channel average changed outside the update step");

endmodule
